[src/rfid_frame_manchester_encoder_defines.svh]
// ---------------------------------------------------------------------------
// RFID frame Manchester encoder: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef RFID_FRAME_MANCHESTER_ENCODER_DEFINES_SVH
`define RFID_FRAME_MANCHESTER_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// checked at every edge outside reset
`define RFME_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");
// implication checked outside reset
`define RFME_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define RFME_ASSERT(lbl, clk, rstn, prop)
`define RFME_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

[src/rfme_pkg.sv]
// ---------------------------------------------------------------------------
// RFID frame Manchester encoder package
// Shared payload types, job record and frame constants.
// ---------------------------------------------------------------------------
package rfme_pkg;

	localparam int NIBBLE_W    = 4;
	localparam int HDR_LEN     = 9;
	localparam logic [HDR_LEN-1:0] HDR_BITS = 9'h1FF;
	localparam int ROW_LEN     = NIBBLE_W + 1;  // nibble + row parity
	localparam int TRL_LEN     = NIBBLE_W + 1;  // column parities + stop bit
	localparam int SEQ_LEN     = HDR_LEN + ROW_LEN + TRL_LEN;
	localparam int LEFT_W      = $clog2(SEQ_LEN + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [NIBBLE_W-1:0] nibble;
		logic                last_nibble;
	} rfme_in_t;

	typedef struct packed {
		logic chip;
		logic run_last;
		logic frame_end;
	} rfme_out_t;

	// one classified row, as handed from front to back
	typedef struct packed {
		logic                has_hdr;
		logic                has_trl;
		logic [ROW_LEN-1:0]  row_bits;  // nibble MSB first, then row parity
		logic [TRL_LEN-1:0]  trl_bits;  // column parity MSB first, then stop
		logic                invert;
	} rfme_job_t;

endpackage

[src/rfme_front.sv]
// ---------------------------------------------------------------------------
// RFME front end
// Accepts rows, tracks frame state and column parity, builds jobs.
// ---------------------------------------------------------------------------
module rfme_front import rfme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  rfme_in_t  item,
	input  logic      invert,
	input  logic      q_full,
	output logic      push,
	output rfme_job_t job
);

	logic                in_frame_q;
	logic [NIBBLE_W-1:0] col_par_q;
	logic [NIBBLE_W-1:0] col_par_next;

	assign item_ready   = !q_full;
	assign push         = item_valid && item_ready;
	// a new frame starts its column parity from zero
	assign col_par_next = (in_frame_q ? col_par_q : '0) ^ item.nibble;

	always_comb begin
		job.has_hdr  = !in_frame_q;
		job.has_trl  = item.last_nibble;
		job.row_bits = {item.nibble, ^item.nibble};
		job.trl_bits = {col_par_next, 1'b0};
		job.invert   = invert;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			col_par_q  <= '0;
		end else if (push) begin
			if (item.last_nibble) begin
				in_frame_q <= 1'b0;
				col_par_q  <= '0;
			end else begin
				in_frame_q <= 1'b1;
				col_par_q  <= col_par_next;
			end
		end
	end

endmodule

[src/rfme_queue.sv]
// ---------------------------------------------------------------------------
// RFME job queue
// Short register FIFO between front and back end.
// ---------------------------------------------------------------------------
`include "rfid_frame_manchester_encoder_defines.svh"

module rfme_queue import rfme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rfme_job_t wr_job,
	input  logic      pop,
	output rfme_job_t rd_job,
	output logic      full,
	output logic      empty
);

	rfme_job_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RFME_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full)
	`RFME_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty)

endmodule

[src/rfme_back.sv]
// ---------------------------------------------------------------------------
// RFME back end
// Serializes jobs into Manchester chips through an output register.
// ---------------------------------------------------------------------------
`include "rfid_frame_manchester_encoder_defines.svh"

module rfme_back import rfme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rfme_job_t job,
	input  logic      q_empty,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output rfme_out_t result
);

	logic               busy_q;
	logic               phase_q;   // 0: first half-bit, 1: complement
	logic [SEQ_LEN-1:0] seq_q;     // remaining bits, next one at the MSB
	logic [LEFT_W-1:0]  left_q;
	logic               trl_q;
	logic               inv_q;
	logic               out_valid_q;
	rfme_out_t          out_q;

	logic               adv;
	logic               last_chip;
	rfme_out_t          cur;
	logic [SEQ_LEN-1:0] load_seq;
	logic [LEFT_W-1:0]  load_left;

	assign adv       = !out_valid_q || result_ready;
	assign last_chip = phase_q && (left_q == LEFT_W'(1));
	assign pop       = adv && (!busy_q || last_chip) && !q_empty;

	always_comb begin
		cur.chip      = seq_q[SEQ_LEN-1] ^ inv_q ^ phase_q;
		cur.run_last  = last_chip;
		cur.frame_end = last_chip && trl_q;
	end

	always_comb begin
		if (job.has_hdr) begin
			load_seq = {HDR_BITS, job.row_bits, job.trl_bits};
		end else begin
			load_seq = {job.row_bits, job.trl_bits, {HDR_LEN{1'b0}}};
		end
		load_left = LEFT_W'(ROW_LEN)
			+ (job.has_hdr ? LEFT_W'(HDR_LEN) : '0)
			+ (job.has_trl ? LEFT_W'(TRL_LEN) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= busy_q;
			// a new job loads on the last chip of the previous one
			if (pop) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				left_q  <= load_left;
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					left_q <= left_q - 1'b1;
				end
				if (last_chip) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				out_q <= cur;
			end
			if (pop) begin
				seq_q <= load_seq;
				trl_q <= job.has_trl;
				inv_q <= job.invert;
			end else if (busy_q && phase_q) begin
				seq_q <= {seq_q[SEQ_LEN-2:0], 1'b0};
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`RFME_ASSERT_IMP(a_busy_has_bits, clk, arst_n, busy_q, left_q != '0)
	`RFME_ASSERT_IMP(a_end_is_run_last, clk, arst_n,
		out_valid_q && out_q.frame_end, out_q.run_last)

endmodule

[src/rfid_frame_manchester_encoder.sv]
// ---------------------------------------------------------------------------
// RFID frame Manchester encoder
// EM4100-style frame builder with Manchester line coding.
// ---------------------------------------------------------------------------
// Each accepted request carries one 4-bit data row. The block sends it MSB
// first plus an even row parity, as Manchester chips (bit, then complement),
// one chip per result request. The first row of a frame is preceded by a
// nine-bit header of ones; the row marked last_nibble is followed by the four
// column parities (MSB column first) and a 0 stop bit, and closes the frame.
// A row therefore yields 10 chips, 28 with header, 38 with header and
// trailer. The serializer emits one chip per clock while the receiver is
// ready; the front end accepts rows into a two-entry queue whenever it has
// room, and after the first row of a burst chips leave without gaps while
// result_ready stays high. The invert setting (cfg_data bit 0) is sampled
// when a row is accepted and XORs every chip of that row. cfg_ready is
// always high; write it only while no row is in flight.
// ---------------------------------------------------------------------------
module rfid_frame_manchester_encoder import rfme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	// row requests
	input  logic      item_valid,
	output logic      item_ready,
	input  rfme_in_t  item,
	// chip results
	output logic      result_valid,
	input  logic      result_ready,
	output rfme_out_t result,
	// configuration write: bit 0 = invert_output
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	logic      invert_q;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;
	rfme_job_t fr_job;
	rfme_job_t bk_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			invert_q <= cfg_data;
		end
	end

	// classify rows and keep frame/column parity state
	rfme_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.invert     (invert_q),
		.q_full     (q_full),
		.push       (push),
		.job        (fr_job)
	);

	// decouples acceptance from serialization
	rfme_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (fr_job),
		.pop    (pop),
		.rd_job (bk_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// chip serializer with registered output
	rfme_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (bk_job),
		.q_empty      (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[verif/rfid_frame_manchester_encoder_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RFID frame Manchester encoder testbench
// Drives data rows into the encoder and checks every line chip against a
// frame predictor kept in a scoreboard: header, row bits, row parity,
// column parities, stop bit, run_last and frame_end marks, and the invert
// setting. Directed frames first, then random frames under random stalls on
// both sides, a long receiver hold-off and config changes between phases.
// ---------------------------------------------------------------------------
module rfid_frame_manchester_encoder_tb;
	import rfme_pkg::*;

	// Frame predictor plus queue of chips still owed by the block.
	class manchester_chip_board;
		rfme_out_t   chips_due[$];
		bit          frame_open;
		logic [NIBBLE_W-1:0] col_par;
		bit          invert;
		int unsigned rows, frames, headers, chips_ok, errors;

		function new();
			frame_open = 1'b0;
			col_par    = '0;
			invert     = 1'b0;
			rows = 0; frames = 0; headers = 0; chips_ok = 0; errors = 0;
		endfunction

		function void set_invert(bit v);
			invert = v;
		endfunction

		// one coded bit -> two chips: level, then its complement
		function void push_bit(bit b, bit row_end, bit frm_end);
			rfme_out_t c;
			c.chip      = b ^ invert;
			c.run_last  = 1'b0;
			c.frame_end = 1'b0;
			chips_due.push_back(c);
			c.chip      = ~c.chip;
			c.run_last  = row_end;
			c.frame_end = frm_end;
			chips_due.push_back(c);
		endfunction

		// accepted row request: append every chip it must produce
		function void note_row(rfme_in_t r);
			int j;
			if (!frame_open) begin
				for (j = HDR_LEN - 1; j >= 0; j--)
					push_bit(HDR_BITS[j], 1'b0, 1'b0);
				frame_open = 1'b1;
				col_par    = '0;
				headers++;
			end
			for (j = NIBBLE_W - 1; j >= 0; j--)
				push_bit(r.nibble[j], 1'b0, 1'b0);
			// even row parity; ends the run unless a trailer follows
			push_bit(^r.nibble, !r.last_nibble, 1'b0);
			col_par ^= r.nibble;
			if (r.last_nibble) begin
				for (j = NIBBLE_W - 1; j >= 0; j--)
					push_bit(col_par[j], 1'b0, 1'b0);
				push_bit(1'b0, 1'b1, 1'b1);
				frame_open = 1'b0;
				col_par    = '0;
				frames++;
			end
			rows++;
		endfunction

		function void check_chip(rfme_out_t got);
			rfme_out_t want;
			if (chips_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: chip with none due: chip=%b run_last=%b frame_end=%b",
						$time, got.chip, got.run_last, got.frame_end);
				return;
			end
			want = chips_due.pop_front();
			if (got.chip !== want.chip || got.run_last !== want.run_last ||
					got.frame_end !== want.frame_end) begin
				errors++;
				if (errors <= 10)
					$display("%0t: chip mismatch: exp chip=%b run_last=%b frame_end=%b, got chip=%b run_last=%b frame_end=%b",
						$time, want.chip, want.run_last, want.frame_end,
						got.chip, got.run_last, got.frame_end);
			end else begin
				chips_ok++;
			end
		endfunction

		function int chips_pending();
			return chips_due.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	rfme_in_t  item;
	logic      result_valid;
	logic      result_ready;
	rfme_out_t result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;

	manchester_chip_board sb;

	bit          tx_idle_en;   // sender may insert gaps
	bit          rx_idle_en;   // receiver may stall
	bit          hold_req;     // receiver long hold-off request
	int unsigned hold_len;
	int unsigned cfg_writes;

	rfid_frame_manchester_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run, with every chip stalled.
	initial begin
		#8_000_000;
		$display("rfid_frame_manchester_encoder_tb: errors");
		$finish;
	end

	// Monitor: row request noted before any chip of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				sb.note_row(item);
			if (result_valid && result_ready)
				sb.check_chip(result);
		end
	end

	// Receiver: random stall bursts, or a long hold-off counted here on request.
	initial begin : rx_side
		int unsigned stall;
		stall        = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall != 0) begin
				result_ready <= 1'b0;
				stall--;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Offer one row request; valid stays high into the next request when no
	// gap is taken, so back-to-back rows never toggle valid within a step.
	task automatic send_row(input logic [NIBBLE_W-1:0] nib, input bit last);
		int unsigned gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid       <= 1'b1;
		item.nibble      <= nib;
		item.last_nibble <= last;
		do @(posedge clk); while (!item_ready);
	endtask

	// Drop valid, then wait until every owed chip has come out.
	task automatic drain_chips();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.chips_pending() != 0) @(negedge clk);
	endtask

	// Only called with no row in flight.
	task automatic cfg_write(input bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_invert(v);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random frames: mostly 2..6 rows, some single-row, some long.
	task automatic random_frames(input int unsigned n);
		int unsigned sent, len, pick, k;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 5);
			if (pick == 0)
				len = 1;
			else if (pick == 5)
				len = $urandom_range(7, 16);
			else
				len = $urandom_range(2, 6);
			for (k = 0; k < len; k++)
				send_row(4'($urandom_range(0, 15)), k == len - 1);
			sent += len;
		end
	endtask

	initial begin : stimulus
		int ph;
		sb          = new();
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b0;
		hold_req    = 1'b0;
		hold_len    = 0;
		cfg_writes  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		cfg_write(1'b0);
		// single-row frames: header, row and trailer from one request
		send_row(4'h0, 1'b1);
		send_row(4'hF, 1'b1);
		// walking one through the nibble, then all ones and zero
		send_row(4'h1, 1'b0);
		send_row(4'h2, 1'b0);
		send_row(4'h4, 1'b0);
		send_row(4'h8, 1'b0);
		send_row(4'hF, 1'b0);
		send_row(4'h0, 1'b1);
		send_row(4'h7, 1'b0);
		send_row(4'h9, 1'b1);
		drain_chips();
		cfg_write(1'b1);
		send_row(4'h6, 1'b1);
		send_row(4'hC, 1'b0);
		send_row(4'h3, 1'b1);
		// invert change between two rows of the same frame
		send_row(4'hE, 1'b0);
		drain_chips();
		cfg_write(1'b0);
		send_row(4'h1, 1'b1);
		drain_chips();

		// --- random phases, config change between each ---
		for (ph = 0; ph < 8; ph++) begin
			rx_idle_en = (ph != 1) && (ph < 6);
			tx_idle_en = (ph != 3) && (ph < 6);
			if (ph == 2) begin
				// receiver stops long enough to back the block up
				hold_len = 300;
				hold_req = 1'b1;
			end
			if (ph == 4) begin
				random_frames(27);
				drain_chips();   // sender pause until all chips are out
				random_frames(28);
			end else begin
				random_frames(55);
			end
			drain_chips();
			cfg_write(1'($urandom_range(0, 1)));
		end

		drain_chips();
		// tail: nothing further may come out
		repeat (40) @(negedge clk);
		$display("covered %0d rows in %0d frames (%0d headers), %0d chips matched",
			sb.rows, sb.frames, sb.headers, sb.chips_ok);
		$display("%0d invert writes, %0d chip errors", cfg_writes, sb.errors);
		if (sb.errors == 0 && sb.chips_pending() == 0)
			$display("rfid_frame_manchester_encoder_tb: clean");
		else
			$display("rfid_frame_manchester_encoder_tb: errors");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/rfme_pkg.sv
src/rfme_front.sv
src/rfme_queue.sv
src/rfme_back.sv
src/rfid_frame_manchester_encoder.sv
verif/rfid_frame_manchester_encoder_tb.sv
